// ----- design/pip_pkg.sv -----
// Shared types and widths for the point-in-region pipeline.
// Holds the query and result word layouts; depends on nothing.
`default_nettype none

package pip_pkg;

	localparam int COORD_W = 24;              // input coordinate width
	localparam int DIFF_W  = COORD_W + 1;     // edge vector component
	localparam int PROD_W  = 2 * DIFF_W;      // one partial product
	localparam int CROSS_W = PROD_W + 1;      // cross product
	localparam int SUM_W   = CROSS_W + 1;     // cu + cv

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index taken from paddr[2]
	localparam logic REG_REGION_SHAPE = 1'b0;

	// region_shape codes
	localparam logic SHAPE_TRIANGLE = 1'b0;
	localparam logic SHAPE_QUAD     = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] corner_a_x;
		logic signed [COORD_W-1:0] corner_a_y;
		logic signed [COORD_W-1:0] corner_b_x;
		logic signed [COORD_W-1:0] corner_b_y;
		logic signed [COORD_W-1:0] corner_c_x;
		logic signed [COORD_W-1:0] corner_c_y;
		logic signed [COORD_W-1:0] corner_d_x;
		logic signed [COORD_W-1:0] corner_d_y;
	} query_t;

	typedef struct packed {
		logic inside_res;
		logic degenerate;
	} result_t;

endpackage

`default_nettype wire

// ----- design/point_in_platoon_region.sv -----
// Top level of the point-in-region test: five-stage barycentric pipeline.
// Depends on pip_pkg for word types and widths.
//
// Usage:
//   Query channel (query_valid / query_ready / query) carries one word per
//   test: point P and corners A, B, C, D in signed fixed point. The result
//   channel (result_valid / result_ready / result) returns one word per
//   query, in order: inside_res (P in region, edges included) and
//   degenerate (a tested triangle had zero area).
//   region_shape, written over the APB port at byte address 0, selects
//   triangle ABC (0) or quadrilateral ABCD as ABC or ACD (1). Bit 0 only.
//   Write it only while no query is in flight.
// Pipeline:
//   An accepted word is registered into stage 1 and then moves through
//   stages 2 to 5 in order; result_valid is stage 5's valid bit. Stages: edge
//   vectors, twelve 25x25 products, cross products, cu+cv sum, compare.
// Reset and stall:
//   arst_n clears all stage valid bits and region_shape. When the receiver
//   holds result_ready low, the output word holds and each stage advances
//   only into an empty or moving stage, so bubbles collapse and no word is
//   lost or repeated. One query per cycle is sustained while the receiver keeps up.
`default_nettype none

module point_in_platoon_region (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              query_valid,
	output logic                             query_ready,
	input  wire  pip_pkg::query_t            query,
	output logic                             result_valid,
	input  wire                              result_ready,
	output pip_pkg::result_t                 result,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [pip_pkg::PADDR_W-1:0]      paddr,
	input  wire  [pip_pkg::PDATA_W-1:0]      pwdata,
	output logic [pip_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready
);

	// per-triangle stage payloads
	typedef struct packed {
		logic signed [pip_pkg::DIFF_W-1:0] e0x, e0y, e1x, e1y, e2x, e2y;
	} edges_t;

	typedef struct packed {
		logic signed [pip_pkg::PROD_W-1:0] k0, k1, u0, u1, v0, v1;
	} prods_t;

	typedef struct packed {
		logic signed [pip_pkg::CROSS_W-1:0] k, cu, cv;
	} cross_t;

	typedef struct packed {
		logic signed [pip_pkg::CROSS_W-1:0] k;
		logic signed [pip_pkg::SUM_W-1:0]   sum;
		logic                               k_zero;
		logic                               k_neg;
		logic                               cu_zero;
		logic                               cu_neg;
		logic                               cv_zero;
		logic                               cv_neg;
	} sign_t;

	function automatic logic signed [pip_pkg::DIFF_W-1:0] sub_c(
		input logic signed [pip_pkg::COORD_W-1:0] a,
		input logic signed [pip_pkg::COORD_W-1:0] b
	);
		return pip_pkg::DIFF_W'(a) - pip_pkg::DIFF_W'(b);
	endfunction

	function automatic logic signed [pip_pkg::PROD_W-1:0] mul_e(
		input logic signed [pip_pkg::DIFF_W-1:0] a,
		input logic signed [pip_pkg::DIFF_W-1:0] b
	);
		logic signed [pip_pkg::PROD_W-1:0] wa;
		logic signed [pip_pkg::PROD_W-1:0] wb;
		wa = pip_pkg::PROD_W'(a);
		wb = pip_pkg::PROD_W'(b);
		return wa * wb;
	endfunction

	// ---------------- configuration port ----------------
	logic region_shape_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_shape_q <= pip_pkg::SHAPE_TRIANGLE;
		end else if (cfg_wr && paddr[2] == pip_pkg::REG_REGION_SHAPE) begin
			region_shape_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == pip_pkg::REG_REGION_SHAPE) begin
			prdata[0] = region_shape_q;
		end
	end

	// ---------------- stage handshake ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// a stage may load when it is empty or its word moves on
	assign rdy5 = !v_s5 || result_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign query_ready  = rdy1;
	assign result_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= query_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: edge vectors ----------------
	// triangle 0 is ABC, triangle 1 is ACD
	edges_t edg_s1 [2];
	logic   shape_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && query_valid) begin
			shape_s1     <= region_shape_q;
			edg_s1[0].e0x <= sub_c(query.corner_b_x, query.corner_a_x);
			edg_s1[0].e0y <= sub_c(query.corner_b_y, query.corner_a_y);
			edg_s1[0].e1x <= sub_c(query.corner_c_x, query.corner_a_x);
			edg_s1[0].e1y <= sub_c(query.corner_c_y, query.corner_a_y);
			edg_s1[0].e2x <= sub_c(query.point_x, query.corner_a_x);
			edg_s1[0].e2y <= sub_c(query.point_y, query.corner_a_y);
			edg_s1[1].e0x <= sub_c(query.corner_c_x, query.corner_a_x);
			edg_s1[1].e0y <= sub_c(query.corner_c_y, query.corner_a_y);
			edg_s1[1].e1x <= sub_c(query.corner_d_x, query.corner_a_x);
			edg_s1[1].e1y <= sub_c(query.corner_d_y, query.corner_a_y);
			edg_s1[1].e2x <= sub_c(query.point_x, query.corner_a_x);
			edg_s1[1].e2y <= sub_c(query.point_y, query.corner_a_y);
		end
	end

	// ---------------- stage 2: partial products ----------------
	// k = e0 x e1, cu = e2 x e1, cv = e0 x e2
	prods_t prd_s2 [2];
	logic   shape_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			shape_s2 <= shape_s1;
			for (int t = 0; t < 2; t++) begin
				prd_s2[t].k0 <= mul_e(edg_s1[t].e0x, edg_s1[t].e1y);
				prd_s2[t].k1 <= mul_e(edg_s1[t].e0y, edg_s1[t].e1x);
				prd_s2[t].u0 <= mul_e(edg_s1[t].e2x, edg_s1[t].e1y);
				prd_s2[t].u1 <= mul_e(edg_s1[t].e2y, edg_s1[t].e1x);
				prd_s2[t].v0 <= mul_e(edg_s1[t].e0x, edg_s1[t].e2y);
				prd_s2[t].v1 <= mul_e(edg_s1[t].e0y, edg_s1[t].e2x);
			end
		end
	end

	// ---------------- stage 3: cross products ----------------
	cross_t crs_s3 [2];
	logic   shape_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			shape_s3 <= shape_s2;
			for (int t = 0; t < 2; t++) begin
				crs_s3[t].k  <= pip_pkg::CROSS_W'(prd_s2[t].k0)
				              - pip_pkg::CROSS_W'(prd_s2[t].k1);
				crs_s3[t].cu <= pip_pkg::CROSS_W'(prd_s2[t].u0)
				              - pip_pkg::CROSS_W'(prd_s2[t].u1);
				crs_s3[t].cv <= pip_pkg::CROSS_W'(prd_s2[t].v0)
				              - pip_pkg::CROSS_W'(prd_s2[t].v1);
			end
		end
	end

	// ---------------- stage 4: cu + cv and sign flags ----------------
	sign_t sgn_s4 [2];
	logic  shape_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			shape_s4 <= shape_s3;
			for (int t = 0; t < 2; t++) begin
				sgn_s4[t].k       <= crs_s3[t].k;
				sgn_s4[t].sum     <= pip_pkg::SUM_W'(crs_s3[t].cu)
				                   + pip_pkg::SUM_W'(crs_s3[t].cv);
				sgn_s4[t].k_zero  <= (crs_s3[t].k == '0);
				sgn_s4[t].k_neg   <= crs_s3[t].k[pip_pkg::CROSS_W-1];
				sgn_s4[t].cu_zero <= (crs_s3[t].cu == '0);
				sgn_s4[t].cu_neg  <= crs_s3[t].cu[pip_pkg::CROSS_W-1];
				sgn_s4[t].cv_zero <= (crs_s3[t].cv == '0);
				sgn_s4[t].cv_neg  <= crs_s3[t].cv[pip_pkg::CROSS_W-1];
			end
		end
	end

	// ---------------- stage 5: decision, output register ----------------
	// With k > 0: cu >= 0, cv >= 0, cu+cv <= k.
	// With k < 0: cu <= 0, cv <= 0, cu+cv >= k.
	logic [1:0] tri_in;
	logic [1:0] tri_deg;

	always_comb begin
		logic signed [pip_pkg::SUM_W-1:0] k_w;
		logic u_ok, v_ok, s_ok;
		for (int t = 0; t < 2; t++) begin
			k_w = pip_pkg::SUM_W'(sgn_s4[t].k);
			if (sgn_s4[t].k_neg) begin
				u_ok = sgn_s4[t].cu_neg || sgn_s4[t].cu_zero;
				v_ok = sgn_s4[t].cv_neg || sgn_s4[t].cv_zero;
				s_ok = (sgn_s4[t].sum >= k_w);
			end else begin
				u_ok = !sgn_s4[t].cu_neg;
				v_ok = !sgn_s4[t].cv_neg;
				s_ok = (sgn_s4[t].sum <= k_w);
			end
			tri_deg[t] = sgn_s4[t].k_zero;
			tri_in[t]  = !sgn_s4[t].k_zero && u_ok && v_ok && s_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			if (shape_s4 == pip_pkg::SHAPE_QUAD) begin
				result.inside_res <= tri_in[0] | tri_in[1];
				result.degenerate <= tri_deg[0] | tri_deg[1];
			end else begin
				result.inside_res <= tri_in[0];
				result.degenerate <= tri_deg[0];
			end
		end
	end

endmodule

`default_nettype wire

// ----- verif/tb_point_in_platoon_region.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the point-in-region pipeline: query words in, inside/degenerate
// result words out, region_shape set over APB. Depends on pip_pkg and point_in_platoon_region.

module tb_point_in_platoon_region;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 4;
	localparam int RESULT_LATENCY = 5;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int HOLD_OFF_CYCLES = 60;

	localparam longint COORD_MIN = -(64'sd1 <<< (pip_pkg::COORD_W - 1));
	localparam longint COORD_MAX = (64'sd1 <<< (pip_pkg::COORD_W - 1)) - 1;

	// byte addresses: register index i sits at 4*i
	localparam logic [pip_pkg::PADDR_W-1:0] ADDR_REGION_SHAPE =
		{pip_pkg::REG_REGION_SHAPE, 2'b00};
	localparam logic [pip_pkg::PADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

	// clock, reset and every block input start at a known value
	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         query_valid  = 1'b0;
	pip_pkg::query_t              query        = '0;
	logic                         result_ready = 1'b0;
	logic                         psel         = 1'b0;
	logic                         penable      = 1'b0;
	logic                         pwrite       = 1'b0;
	logic [pip_pkg::PADDR_W-1:0]  paddr        = '0;
	logic [pip_pkg::PDATA_W-1:0]  pwdata       = '0;

	logic                         query_ready;
	logic                         result_valid;
	pip_pkg::result_t             result;
	logic [pip_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	// local copy of region_shape, updated on every completed APB write to it
	logic                         shape_model = pip_pkg::SHAPE_TRIANGLE;
	pip_pkg::result_t             expected_results[$];
	int                           fail_count   = 0;
	int                           cycle_count  = 0;
	int                           sender_idle_pct = 0;
	int                           receiver_stall_pct = 0;
	int                           hold_req     = 0;
	int                           hold_left    = 0;

	point_in_platoon_region u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query        (query),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Hard stop: a hung handshake or a lost word ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("point_in_platoon_region regression: fail");
			$finish;
		end
	end

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
			want);
		fail_count++;
	endtask

	// Append one prediction at the tail of the pending list.
	task automatic enqueue_expected(input pip_pkg::result_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	// Test one triangle A,B,C against P. Returns {hit, zero_area}.
	// Compare u and v against the denominator without dividing: flip signs when the
	// area is negative, then u >= 0, v >= 0 and u + v <= |k|. Edges count as inside.
	function automatic logic [1:0] triangle_hit(input longint px, input longint py,
			input longint ax, input longint ay, input longint bx, input longint by,
			input longint cx, input longint cy);
		longint e0x, e0y, e1x, e1y, e2x, e2y, area, cu, cv;
		e0x = bx - ax;  e0y = by - ay;
		e1x = cx - ax;  e1y = cy - ay;
		e2x = px - ax;  e2y = py - ay;
		area = e0x * e1y - e0y * e1x;
		cu   = e2x * e1y - e2y * e1x;
		cv   = e0x * e2y - e0y * e2x;
		if (area == 0)
			return 2'b01;
		if (area < 0) begin
			area = -area;
			cu   = -cu;
			cv   = -cv;
		end
		return {(cu >= 0) && (cv >= 0) && (cu + cv <= area), 1'b0};
	endfunction

	// Expected result word for one query under the given region shape.
	function automatic pip_pkg::result_t predict_region(input pip_pkg::query_t q,
			input logic shape);
		pip_pkg::result_t r;
		logic [1:0]       abc, acd;
		abc = triangle_hit($signed(q.point_x), $signed(q.point_y),
			$signed(q.corner_a_x), $signed(q.corner_a_y),
			$signed(q.corner_b_x), $signed(q.corner_b_y),
			$signed(q.corner_c_x), $signed(q.corner_c_y));
		r.inside_res = abc[1];
		r.degenerate = abc[0];
		if (shape == pip_pkg::SHAPE_QUAD) begin
			// both halves are always evaluated, so either one can flag zero area
			acd = triangle_hit($signed(q.point_x), $signed(q.point_y),
				$signed(q.corner_a_x), $signed(q.corner_a_y),
				$signed(q.corner_c_x), $signed(q.corner_c_y),
				$signed(q.corner_d_x), $signed(q.corner_d_y));
			r.inside_res = r.inside_res | acd[1];
			r.degenerate = r.degenerate | acd[0];
		end
		return r;
	endfunction

	function automatic pip_pkg::query_t make_query(input longint px, input longint py,
			input longint ax, input longint ay, input longint bx, input longint by,
			input longint cx, input longint cy, input longint dx, input longint dy);
		pip_pkg::query_t q;
		q.point_x    = pip_pkg::COORD_W'(px);  q.point_y    = pip_pkg::COORD_W'(py);
		q.corner_a_x = pip_pkg::COORD_W'(ax);  q.corner_a_y = pip_pkg::COORD_W'(ay);
		q.corner_b_x = pip_pkg::COORD_W'(bx);  q.corner_b_y = pip_pkg::COORD_W'(by);
		q.corner_c_x = pip_pkg::COORD_W'(cx);  q.corner_c_y = pip_pkg::COORD_W'(cy);
		q.corner_d_x = pip_pkg::COORD_W'(dx);  q.corner_d_y = pip_pkg::COORD_W'(dy);
		return q;
	endfunction

	function automatic longint extreme_coord();
		case ($urandom_range(6))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return COORD_MIN + 1;
			3: return COORD_MAX - 1;
			4: return -1;
			5: return 1;
			default: return 0;
		endcase
	endfunction

	// Random query. Most kinds build meaningful geometry (small grids that hit edges
	// and collinear corners, points blended inside a half, points on a corner or the
	// shared diagonal, zero-area triangles); the rest is raw bits and extremes.
	function automatic pip_pkg::query_t random_query();
		longint c[10];
		longint w1, w2;
		int     kind, i, pick, base;
		kind = $urandom_range(9);
		case (kind)
			0, 1: begin
				for (i = 0; i < 10; i++)
					c[i] = longint'($urandom);
			end
			2, 3, 4: begin
				for (i = 0; i < 10; i++)
					c[i] = (kind == 4) ? longint'($urandom_range(8)) - 4
						: longint'($urandom_range(80)) - 40;
			end
			5, 6: begin
				for (i = 2; i < 10; i++)
					c[i] = longint'($urandom_range(1 << 21)) - (1 << 20);
				w1   = $urandom_range(256);
				w2   = $urandom_range(256 - w1);
				base = (kind == 5) ? 4 : 6;
				for (i = 0; i < 2; i++)
					c[i] = c[2+i] + (w1 * (c[base+i] - c[2+i])
						+ w2 * (c[base+2+i] - c[2+i])) / 256;
			end
			7: begin
				for (i = 0; i < 10; i++)
					c[i] = longint'($urandom_range(1 << 17)) - (1 << 16);
				pick = $urandom_range(2);
				for (i = 0; i < 2; i++) begin
					if (pick == 0)
						c[4+i] = c[2+i];
					else if (pick == 1)
						c[6+i] = c[2+i] + 2 * (c[4+i] - c[2+i]);
					else
						c[8+i] = c[2+i] + 3 * (c[6+i] - c[2+i]);
				end
			end
			8: begin
				for (i = 2; i < 10; i++)
					c[i] = (longint'($urandom_range(1 << 21)) - (1 << 20)) & ~longint'(1);
				pick = $urandom_range(4);
				for (i = 0; i < 2; i++)
					c[i] = (pick == 4) ? (c[2+i] + c[6+i]) / 2 : c[2 + 2*pick + i];
			end
			default: begin
				for (i = 0; i < 10; i++)
					c[i] = extreme_coord();
			end
		endcase
		return make_query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9]);
	endfunction

	// Offer one query word: idle first at the current sender rate, then raise valid
	// and hold it with the payload until the block takes the word. Record the
	// prediction at the accepting edge, so it uses the shape in force for that word.
	task automatic offer_query(input pip_pkg::query_t q);
		while ($urandom_range(99) < sender_idle_pct) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query       <= q;
		@(posedge clk);
		while (!query_ready)
			@(posedge clk);
		enqueue_expected(predict_region(q, shape_model));
	endtask

	// Drop valid, wait for every outstanding result word, then let the pipe settle.
	// Anything still pending after the limit is a lost word: report and flush it.
	task automatic drain_results();
		int waited;
		waited = 0;
		query_valid <= 1'b0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (RESULT_LATENCY + 3) @(posedge clk);
		if (expected_results.size() != 0) begin
			report_mismatch("results never returned", expected_results.size(), 0);
			expected_results.delete();
		end
	endtask

	// APB transfer: setup cycle, then access cycle until pready. The write lands at
	// the edge where psel, penable, pwrite and pready are all high. Then idle after
	// the access so back-to-back transfers keep a gap.
	task automatic apb_transfer(input logic is_write,
			input logic [pip_pkg::PADDR_W-1:0] addr,
			input logic [pip_pkg::PDATA_W-1:0] wdata,
			output logic [pip_pkg::PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		if (is_write && addr == ADDR_REGION_SHAPE)
			shape_model = wdata[0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_region_shape(input logic [pip_pkg::PDATA_W-1:0] value);
		logic [pip_pkg::PDATA_W-1:0] unused;
		apb_transfer(1'b1, ADDR_REGION_SHAPE, value, unused);
	endtask

	task automatic check_region_shape_readback();
		logic [pip_pkg::PDATA_W-1:0] rdata;
		apb_transfer(1'b0, ADDR_REGION_SHAPE, '0, rdata);
		if (rdata !== {{(pip_pkg::PDATA_W-1){1'b0}}, shape_model})
			report_mismatch("region_shape readback", rdata, 32'(shape_model));
	endtask

	// Reset value, both codes, upper data bits ignored, unmapped index ignored.
	task automatic test_register_access();
		logic [pip_pkg::PDATA_W-1:0] unused;
		check_region_shape_readback();
		write_region_shape(pip_pkg::PDATA_W'(pip_pkg::SHAPE_QUAD));
		check_region_shape_readback();
		apb_transfer(1'b1, ADDR_UNMAPPED, {pip_pkg::PDATA_W{1'b0}}, unused);
		check_region_shape_readback();
		write_region_shape({{(pip_pkg::PDATA_W-1){1'b1}}, pip_pkg::SHAPE_TRIANGLE});
		check_region_shape_readback();
	endtask

	// Triangle mode: inside, outside, corner, edge, both windings, zero-area
	// triangles, full-range coordinates, and a D that must not matter.
	task automatic test_triangle_cases();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		drain_results();
		write_region_shape(pip_pkg::PDATA_W'(pip_pkg::SHAPE_TRIANGLE));
		offer_query(make_query(64, 64, 0, 0, 256, 0, 0, 256, 0, 0));
		offer_query(make_query(256, 256, 0, 0, 256, 0, 0, 256, 0, 0));
		offer_query(make_query(0, 0, 0, 0, 256, 0, 0, 256, 0, 0));
		offer_query(make_query(128, 128, 0, 0, 256, 0, 0, 256, 0, 0));
		offer_query(make_query(-1, 0, 0, 0, 256, 0, 0, 256, 0, 0));
		offer_query(make_query(64, 64, 0, 0, 0, 256, 256, 0, 0, 0));
		offer_query(make_query(100, 100, 0, 0, 256, 256, 512, 512, 0, 0));
		offer_query(make_query(7, 7, 7, 7, 7, 7, 7, 7, 7, 7));
		offer_query(make_query(0, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
			COORD_MIN, COORD_MAX, 0, 0));
		offer_query(make_query(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MAX, 0, 0));
		offer_query(make_query(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MIN, COORD_MAX, 0, 0));
		offer_query(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
			COORD_MAX, COORD_MAX, COORD_MIN, 0, 0));
		offer_query(make_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		offer_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		offer_query(make_query(-64, 128, 0, 0, 256, 0, 0, 256, -256, 256));
	endtask

	// Quadrilateral mode on a square split along AC: each half alone, neither, the
	// diagonal, one half of zero area, both of zero area, a full-range corner.
	task automatic test_quad_cases();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		drain_results();
		write_region_shape(pip_pkg::PDATA_W'(pip_pkg::SHAPE_QUAD));
		offer_query(make_query(64, 192, 0, 0, 256, 0, 256, 256, 0, 256));
		offer_query(make_query(192, 64, 0, 0, 256, 0, 256, 256, 0, 256));
		offer_query(make_query(300, 100, 0, 0, 256, 0, 256, 256, 0, 256));
		offer_query(make_query(128, 128, 0, 0, 256, 0, 256, 256, 0, 256));
		offer_query(make_query(192, 64, 0, 0, 256, 0, 256, 256, 512, 512));
		offer_query(make_query(64, 192, 0, 0, 128, 128, 256, 256, 0, 256));
		offer_query(make_query(3, 3, 3, 3, 3, 3, 3, 3, 3, 3));
		offer_query(make_query(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX));
	endtask

	// One random phase: set the shape while idle, then stream words at the given
	// sender idle and receiver stall rates.
	task automatic test_random_traffic(input logic shape, input int idle_pct,
			input int stall_pct, input int count);
		drain_results();
		write_region_shape(pip_pkg::PDATA_W'(shape));
		check_region_shape_readback();
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (count)
			offer_query(random_query());
	endtask

	// Hold result_ready low for a long stretch while the sender keeps offering,
	// so the pipe fills and query_ready drops; then release and drain.
	task automatic test_output_backpressure();
		drain_results();
		write_region_shape(pip_pkg::PDATA_W'(pip_pkg::SHAPE_QUAD));
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_req = HOLD_OFF_CYCLES;
		repeat (30)
			offer_query(random_query());
	endtask

	// Receiver: count down an armed hold-off first, otherwise stall at the
	// current rate. Only this process drives result_ready.
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Scoreboard: every accepted result word pops the oldest prediction and is
	// compared field by field. A word with nothing pending is a failure too.
	always @(posedge clk) begin : result_check
		pip_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result word with no query pending", 32'(result), 0);
			end else begin
				want = expected_results.pop_front();
				if (result.inside_res !== want.inside_res)
					report_mismatch("inside_res", 32'(result.inside_res),
						32'(want.inside_res));
				if (result.degenerate !== want.degenerate)
					report_mismatch("degenerate", 32'(result.degenerate),
						32'(want.degenerate));
			end
		end
	end

	// Sequence: one reset, register checks, directed cases in both shapes, four
	// random phases across idle and stall mixes, the long hold-off, then drain.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_triangle_cases();
		test_quad_cases();
		test_random_traffic(pip_pkg::SHAPE_TRIANGLE, 0, 0, 170);
		test_random_traffic(pip_pkg::SHAPE_QUAD, 57, 0, 170);
		test_random_traffic(pip_pkg::SHAPE_TRIANGLE, 0, 57, 170);
		test_random_traffic(pip_pkg::SHAPE_QUAD, 19, 19, 170);
		test_output_backpressure();
		drain_results();

		if (fail_count == 0)
			$display("point_in_platoon_region regression: pass");
		else
			$display("point_in_platoon_region regression: fail");
		$finish;
	end

endmodule
